### hw/rtl/ptcr_pkg.sv
// shared types and constants for the planar text cell renderer
package ptcr_pkg;

  // default glyph height in lines
  localparam int GLYPH_LINES_DEF = 14;
  // text columns per screen row, sets the address stride of one glyph line
  localparam int TEXT_COLUMNS = 80;

  // frame buffer page base for the upper page
  localparam logic [15:0] PAGE_BASE = 16'h8000;

  // request kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  // screen modes
  localparam logic [1:0] MODE_GLYPH  = 2'd0;
  localparam logic [1:0] MODE_PAIR_A = 2'd1;
  localparam logic [1:0] MODE_PAIR_B = 2'd2;
  localparam logic [1:0] MODE_OFFSET = 2'd3;

  // register index, taken from paddr bit 2
  localparam logic REG_DISP_MODE = 1'b0;
  localparam logic REG_DRAW_PAGE = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // write the glyph row of the accepted request
    logic start;  // latch the accepted render request
    logic issue;  // read one glyph line and push it down the pipeline
  } ptcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_ok;    // read stage can take a new line
    logic final_line;  // line counter sits on the last glyph line
  } ptcr_status_t;

endpackage

### hw/rtl/ptcr_if.sv
// request channel of text cells and result channel of frame buffer bytes

interface ptcr_cell_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  logic [3:0] glyph_line;
  logic [7:0] glyph_bits;
  logic [3:0] fg_index;
  logic [3:0] bg_index;
  logic [1:0] plane;
  logic [6:0] column;
  logic [4:0] text_row;

  modport source (
    output valid, kind, char_code, glyph_line, glyph_bits, fg_index, bg_index,
           plane, column, text_row,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, glyph_line, glyph_bits, fg_index, bg_index,
           plane, column, text_row,
    output ready
  );
endinterface

interface ptcr_byte_if;
  logic        valid;
  logic        ready;
  logic [15:0] vram_address;
  logic [1:0]  plane_out;
  logic [7:0]  pixel_byte;
  logic        last;

  modport source (
    output valid, vram_address, plane_out, pixel_byte, last,
    input  ready
  );
  modport sink (
    input  valid, vram_address, plane_out, pixel_byte, last,
    output ready
  );
endinterface

### hw/rtl/planar_text_cell_renderer.sv
// top level of the planar text cell renderer with its register port
//
// Requests come in on cell_in. A load request (kind 0) writes one glyph row
// into the glyph store and gives no result; rows at or beyond the glyph
// height are dropped. A render request (kind 1) reads the glyph's GLYPH_LINES
// rows, one per cycle while byte_out keeps up, from the single read port of
// the store, and sends one frame buffer byte per row on byte_out, last set on
// the final row. The first byte passes the request latch, the read stage and
// the output register before it is presented. A render request keeps the
// input busy until the cell's last glyph read: the next request is taken
// right after it, and within a cell bytes stream at one per cycle while
// byte_out keeps up.
// A read stage and an output register sit in front of byte_out; when the
// receiver stalls they hold their bytes and glyph reads pause until room
// returns, no byte is dropped or repeated.
// The user writes screen mode (address 0) and draw_page (address 4) over APB
// only while idle; the block does not enforce it. Reset clears both registers
// and all valid flags; glyph store contents are undefined until loaded.
module planar_text_cell_renderer #(
  parameter int GLYPH_LINES = ptcr_pkg::GLYPH_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ptcr_cell_if.sink   cell_in,
  ptcr_byte_if.source byte_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptcr_pkg::*;

  logic         disp_mode_sel;
  logic [1:0]   disp_mode;
  logic         draw_page;
  logic         cfg_write;
  logic         in_ready;
  ptcr_cmd_t    cmd;
  ptcr_status_t status;

  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign disp_mode_sel = (paddr[2] == REG_DISP_MODE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_mode <= MODE_GLYPH;
      draw_page <= 1'b0;
    end else if (cfg_write) begin
      if (disp_mode_sel) begin
        disp_mode <= pwdata[1:0];
      end else begin
        draw_page <= pwdata[0];
      end
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_DISP_MODE: prdata = {30'b0, disp_mode};
      REG_DRAW_PAGE: prdata = {31'b0, draw_page};
      default:       prdata = '0;
    endcase
  end

  assign cell_in.ready = in_ready;

  ptcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cell_in.valid),
    .in_kind  (cell_in.kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ptcr_datapath #(
    .GLYPH_LINES (GLYPH_LINES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_in),
    .byte_out  (byte_out),
    .disp_mode (disp_mode),
    .draw_page (draw_page),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### hw/rtl/ptcr_ctrl.sv
// controller: accepts requests and sequences the glyph line reads of a cell
module ptcr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  ptcr_pkg::ptcr_status_t status,
  output ptcr_pkg::ptcr_cmd_t   cmd
);
  import ptcr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    accept     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        accept    = in_valid;
        cmd.load  = accept && (in_kind == KIND_LOAD);
        cmd.start = accept && (in_kind == KIND_RENDER);
        if (cmd.start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = status.issue_ok;
        if (status.issue_ok && status.final_line) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a read is only issued when the read stage has room
  a_issue_room: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.issue_ok)
    else $error("glyph read issued into a stalled read stage");

  // the final line read ends the cell
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && status.final_line) |=> (state == ST_IDLE))
    else $error("cell did not end after its final line");

endmodule

### hw/rtl/ptcr_datapath.sv
// datapath: glyph store, line counter, address step and pixel byte forming
module ptcr_datapath #(
  parameter int GLYPH_LINES = ptcr_pkg::GLYPH_LINES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ptcr_cell_if.sink             cell_in,
  ptcr_byte_if.source           byte_out,
  input  logic [1:0]            disp_mode,
  input  logic                  draw_page,
  input  ptcr_pkg::ptcr_cmd_t   cmd,
  output ptcr_pkg::ptcr_status_t status
);
  import ptcr_pkg::*;

  localparam int LW          = $clog2(GLYPH_LINES);
  // glyph rows are addressed as {code, line}, so each glyph takes 2**LW slots
  localparam int STORE_DEPTH = 256 << LW;
  localparam int ROW_STRIDE  = GLYPH_LINES * TEXT_COLUMNS;

  localparam logic [15:0] ROW_STEP  = 16'(ROW_STRIDE);
  localparam logic [15:0] LINE_STEP = 16'(TEXT_COLUMNS);
  localparam logic [LW-1:0] LAST_LINE = LW'(GLYPH_LINES - 1);
  localparam logic [4:0]  LINE_LIMIT = 5'(GLYPH_LINES);

  logic [7:0] glyph_mem [STORE_DEPTH];

  // latched render request
  logic [7:0]    code_q;
  logic [3:0]    fg_q;
  logic [3:0]    bg_q;
  logic [1:0]    plane_q;
  logic [LW-1:0] line_q;
  logic [15:0]   addr_q;

  // read stage
  logic          s1_valid;
  logic [7:0]    s1_glyph;
  logic [3:0]    s1_fg;
  logic [3:0]    s1_bg;
  logic [1:0]    s1_plane;
  logic [15:0]   s1_addr;
  logic          s1_last;

  // output register
  logic          out_valid;
  logic [15:0]   out_addr;
  logic [1:0]    out_plane;
  logic [7:0]    out_byte;
  logic          out_last;

  logic          out_free;
  logic          s1_move;
  logic [15:0]   cell_base;
  logic [1:0]    pair;
  logic [7:0]    offset_base;
  logic [7:0]    byte_next;
  logic          load_ok;

  assign out_free = !out_valid || byte_out.ready;
  assign s1_move  = s1_valid && out_free;

  assign status.issue_ok   = !s1_valid || out_free;
  assign status.final_line = (line_q == LAST_LINE);

  // first byte address of the cell, wraps to 16 bits
  assign cell_base = (draw_page ? PAGE_BASE : 16'h0000)
                   + ({11'b0, cell_in.text_row} * ROW_STEP)
                   + {9'b0, cell_in.column};

  assign load_ok = ({1'b0, cell_in.glyph_line} < LINE_LIMIT);

  // glyph store write on a load request
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      glyph_mem[{cell_in.char_code, cell_in.glyph_line[LW-1:0]}] <= cell_in.glyph_bits;
    end
  end

  // latch the render request, then step line and address per read
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      code_q  <= cell_in.char_code;
      fg_q    <= cell_in.fg_index;
      bg_q    <= cell_in.bg_index;
      plane_q <= cell_in.plane;
      line_q  <= '0;
      addr_q  <= cell_base;
    end else if (cmd.issue) begin
      line_q  <= line_q + LW'(1);
      addr_q  <= addr_q + LINE_STEP;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_glyph <= glyph_mem[{code_q, line_q}];
      s1_fg    <= fg_q;
      s1_bg    <= bg_q;
      s1_plane <= plane_q;
      s1_addr  <= addr_q;
      s1_last  <= status.final_line;
    end
  end

  // read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.issue) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // glyph pixel pair picked by the plane, plane 0 takes the leftmost pair
  always_comb begin
    case (s1_plane)
      2'd0:    pair = s1_glyph[7:6];
      2'd1:    pair = s1_glyph[5:4];
      2'd2:    pair = s1_glyph[3:2];
      default: pair = s1_glyph[1:0];
    endcase
  end

  assign offset_base = {s1_bg, s1_fg};

  // pixel byte by screen mode
  always_comb begin
    case (disp_mode)
      MODE_GLYPH: begin
        case ({s1_bg[s1_plane], s1_fg[s1_plane]})
          2'b00:   byte_next = 8'h00;
          2'b01:   byte_next = s1_glyph;
          2'b10:   byte_next = ~s1_glyph;
          default: byte_next = 8'hFF;
        endcase
      end
      MODE_OFFSET: begin
        // pairs 1 and 2 trade offsets, so the offset is the pair bit-swapped
        byte_next = offset_base + {6'b0, pair[0], pair[1]};
      end
      default: begin
        case (pair)
          2'd0:    byte_next = {s1_bg, s1_bg};
          2'd1:    byte_next = {s1_bg, s1_fg};
          2'd2:    byte_next = {s1_fg, s1_bg};
          default: byte_next = {s1_fg, s1_fg};
        endcase
      end
    endcase
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_addr  <= s1_addr;
      out_plane <= s1_plane;
      out_byte  <= byte_next;
      out_last  <= s1_last;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (byte_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign byte_out.valid        = out_valid;
  assign byte_out.vram_address = out_addr;
  assign byte_out.plane_out    = out_plane;
  assign byte_out.pixel_byte   = out_byte;
  assign byte_out.last         = out_last;

  // a new cell starts at its first line
  a_start_line: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (line_q == '0))
    else $error("line counter not cleared at cell start");

  // a stalled read stage keeps its line
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("read stage line lost under stall");

  // successive lines of one cell step the address by one glyph line, TEXT_COLUMNS bytes
  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && !cmd.start) |=> (addr_q == $past(addr_q) + LINE_STEP))
    else $error("address did not step by one line");

endmodule
